// ===== src/blfs_pkg.sv =====
// Shared types and constants of the base link fault supervisor.
package blfs_pkg;

    localparam int unsigned CMD_W    = 4;
    localparam int unsigned REASON_W = 3;
    localparam int unsigned TMO_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TMO_W-1:0] TMO_RESET = 16'd50;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 4'd0,
        CMD_LINK_UP    = 4'd1,
        CMD_LINK_DOWN  = 4'd2,
        CMD_FEEDBACK   = 4'd3,
        CMD_VALID_CMD  = 4'd4,
        CMD_INVALIDATE = 4'd5,
        CMD_INVALID    = 4'd6,
        CMD_IO_FAIL    = 4'd7,
        CMD_CFG_FAIL   = 4'd8,
        CMD_ESTOP      = 4'd9,
        CMD_EVALUATE   = 4'd10,
        CMD_RESET      = 4'd11,
        CMD_QUERY      = 4'd12
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_DISC  = 2'd0,
        MODE_WAIT  = 2'd1,
        MODE_READY = 2'd2,
        MODE_FAULT = 2'd3
    } t_mode;

    typedef enum logic [REASON_W-1:0] {
        FLT_NONE    = 3'd0,
        FLT_INVALID = 3'd1,
        FLT_SERIAL  = 3'd2,
        FLT_MCU     = 3'd3,
        FLT_ESTOP   = 3'd4,
        FLT_TIMEOUT = 3'd5
    } t_fault;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CMD_TMO = 2'd0,
        REG_FB_TMO  = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [REASON_W-1:0] down_reason;
        logic                estop_level;
    } t_req;

    typedef struct packed {
        logic [1:0]          mode;
        logic [REASON_W-1:0] fault;
        logic                link_is_open;
        logic                feedback_fresh;
        logic                command_fresh;
        logic                estop_active;
        logic                can_move;
        logic                reset_accepted;
        logic                timeout_transition;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [TMO_W-1:0]     data;
    } t_cfg;

endpackage

// ===== src/blfs_if.sv =====
// Handshake channel interfaces for requests, results and register writes.
interface blfs_req_if;
    logic          valid;
    logic          ready;
    blfs_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface blfs_rsp_if;
    logic          valid;
    logic          ready;
    blfs_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface blfs_cfg_if;
    logic          valid;
    logic          ready;
    blfs_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/base_link_fault_supervisor.sv =====
// Top level of the base link fault supervisor: event register, state update, result register.
//
// Usage:
//   i_req  : one event per request (cmd, down_reason, estop_level), valid/ready.
//   o_rsp  : one snapshot per request (mode, fault, flags, can_move), valid/ready.
//   i_cfg  : register writes (idx 0 command timeout, idx 1 feedback timeout),
//            always ready; write only while no request is in flight.
// Order: an accepted request is held in the request register, and its result
//   appears on o_rsp when the result register loads; the state is updated at
//   that same edge.
// Throughput: one request per cycle while o_rsp.ready is high; the state update is a
//   single pass of flag logic and three age compares, so a request can follow in every cycle.
// Reset (i_rst_n low, synchronous): mode disconnected, no fault, link closed,
//   no feedback or command seen, ages zero, e-stop clear, both timeouts 50.
// Stall: when o_rsp.ready is low the result holds; the request register takes one
//   more request if it is empty, then i_req.ready drops until the result is taken.
// Ages saturate at 2^AGE_WIDTH - 1.
module base_link_fault_supervisor #(
    parameter int unsigned AGE_WIDTH = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    blfs_req_if.sink             i_req,
    blfs_rsp_if.source           o_rsp,
    blfs_cfg_if.sink             i_cfg
);

    localparam int unsigned CMP_W =
        (AGE_WIDTH > blfs_pkg::TMO_W) ? AGE_WIDTH : blfs_pkg::TMO_W;
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

    // timeouts
    logic [blfs_pkg::TMO_W-1:0] r_cmd_tmo, r_fb_tmo;

    // pipeline
    logic            r_in_vld;
    blfs_pkg::t_req  r_req;
    logic            r_out_vld;
    blfs_pkg::t_rsp  r_rsp;
    logic            out_free;
    logic            fire;

    // supervisor state
    blfs_pkg::t_mode  r_mode, n_mode;
    blfs_pkg::t_fault r_fault, n_fault;
    logic             r_link, n_link;
    logic             r_fb_seen, n_fb_seen;
    logic             r_cmd_seen, n_cmd_seen;
    logic             r_estop, n_estop;
    logic [AGE_WIDTH-1:0] r_fb_age, n_fb_age;
    logic [AGE_WIDTH-1:0] r_cmd_age, n_cmd_age;

    blfs_pkg::t_rsp   n_rsp;
    blfs_pkg::t_fault down_code;
    logic             cur_fb_fresh;
    logic             nxt_fb_fresh;
    logic             nxt_cmd_fresh;
    logic             accepted;
    logic             timed_out;

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign fire        = r_in_vld && out_free;
    assign i_req.ready = !r_in_vld || out_free;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_tmo <= blfs_pkg::TMO_RESET;
            r_fb_tmo  <= blfs_pkg::TMO_RESET;
        end else if (i_cfg.valid) begin
            case (blfs_pkg::t_reg_idx'(i_cfg.data.idx))
                blfs_pkg::REG_CMD_TMO: r_cmd_tmo <= i_cfg.data.data;
                blfs_pkg::REG_FB_TMO:  r_fb_tmo  <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req <= i_req.data;
        end
    end

    always_comb begin
        // link down codes above the table count as serial io
        if (r_req.down_reason > blfs_pkg::REASON_W'(blfs_pkg::FLT_TIMEOUT)) begin
            down_code = blfs_pkg::FLT_SERIAL;
        end else begin
            down_code = blfs_pkg::t_fault'(r_req.down_reason);
        end
    end

    assign cur_fb_fresh = r_link && r_fb_seen &&
        (CMP_W'(r_fb_age) <= CMP_W'(r_fb_tmo));

    always_comb begin
        n_mode     = r_mode;
        n_fault    = r_fault;
        n_link     = r_link;
        n_fb_seen  = r_fb_seen;
        n_cmd_seen = r_cmd_seen;
        n_estop    = r_estop;
        n_fb_age   = r_fb_age;
        n_cmd_age  = r_cmd_age;
        accepted   = 1'b0;
        timed_out  = 1'b0;

        case (blfs_pkg::t_cmd'(r_req.cmd))
            blfs_pkg::CMD_TICK: begin
                if (r_fb_age != AGE_MAX) n_fb_age = r_fb_age + 1'b1;
                if (r_cmd_age != AGE_MAX) n_cmd_age = r_cmd_age + 1'b1;
            end
            blfs_pkg::CMD_LINK_UP: begin
                n_link     = 1'b1;
                n_fb_seen  = 1'b0;
                n_cmd_seen = 1'b0;
                n_fb_age   = '0;
                n_cmd_age  = '0;
                if (r_mode != blfs_pkg::MODE_FAULT) n_mode = blfs_pkg::MODE_WAIT;
            end
            blfs_pkg::CMD_LINK_DOWN, blfs_pkg::CMD_IO_FAIL: begin
                n_link     = 1'b0;
                n_fb_seen  = 1'b0;
                n_cmd_seen = 1'b0;
                n_fb_age   = '0;
                n_cmd_age  = '0;
                if (blfs_pkg::t_cmd'(r_req.cmd) == blfs_pkg::CMD_IO_FAIL ||
                    down_code != blfs_pkg::FLT_NONE) begin
                    n_mode = blfs_pkg::MODE_FAULT;
                    if (r_mode != blfs_pkg::MODE_FAULT) begin
                        n_fault = (blfs_pkg::t_cmd'(r_req.cmd) == blfs_pkg::CMD_IO_FAIL)
                                ? blfs_pkg::FLT_SERIAL : down_code;
                    end
                end else if (r_mode != blfs_pkg::MODE_FAULT) begin
                    n_mode = blfs_pkg::MODE_DISC;
                end
            end
            blfs_pkg::CMD_FEEDBACK: begin
                n_fb_seen = 1'b1;
                n_fb_age  = '0;
                if (r_link && r_mode != blfs_pkg::MODE_FAULT) n_mode = blfs_pkg::MODE_READY;
            end
            blfs_pkg::CMD_VALID_CMD: begin
                n_cmd_seen = 1'b1;
                n_cmd_age  = '0;
            end
            blfs_pkg::CMD_INVALIDATE: begin
                n_cmd_seen = 1'b0;
                n_cmd_age  = '0;
            end
            blfs_pkg::CMD_INVALID: begin
                n_mode = blfs_pkg::MODE_FAULT;
                if (r_mode != blfs_pkg::MODE_FAULT) n_fault = blfs_pkg::FLT_INVALID;
            end
            blfs_pkg::CMD_CFG_FAIL: begin
                n_mode = blfs_pkg::MODE_FAULT;
                if (r_mode != blfs_pkg::MODE_FAULT) n_fault = blfs_pkg::FLT_MCU;
            end
            blfs_pkg::CMD_ESTOP: begin
                n_estop = r_req.estop_level;
                if (r_req.estop_level) begin
                    n_mode = blfs_pkg::MODE_FAULT;
                    if (r_mode != blfs_pkg::MODE_FAULT) n_fault = blfs_pkg::FLT_ESTOP;
                end
            end
            blfs_pkg::CMD_EVALUATE: begin
                if (r_mode != blfs_pkg::MODE_FAULT) begin
                    if (!r_link) begin
                        n_mode = blfs_pkg::MODE_DISC;
                    end else if (!r_fb_seen) begin
                        n_mode = blfs_pkg::MODE_WAIT;
                    end else if (!cur_fb_fresh) begin
                        n_mode    = blfs_pkg::MODE_FAULT;
                        n_fault   = blfs_pkg::FLT_TIMEOUT;
                        timed_out = 1'b1;
                    end else begin
                        n_mode = blfs_pkg::MODE_READY;
                    end
                end
            end
            blfs_pkg::CMD_RESET: begin
                if (!r_estop && cur_fb_fresh) begin
                    n_fault    = blfs_pkg::FLT_NONE;
                    n_mode     = blfs_pkg::MODE_READY;
                    n_cmd_seen = 1'b0;
                    n_cmd_age  = '0;
                    accepted   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign nxt_fb_fresh  = n_link && n_fb_seen &&
        (CMP_W'(n_fb_age) <= CMP_W'(r_fb_tmo));
    assign nxt_cmd_fresh = n_cmd_seen &&
        (CMP_W'(n_cmd_age) <= CMP_W'(r_cmd_tmo));

    always_comb begin
        n_rsp.mode               = n_mode;
        n_rsp.fault              = n_fault;
        n_rsp.link_is_open       = n_link;
        n_rsp.feedback_fresh     = nxt_fb_fresh;
        n_rsp.command_fresh      = nxt_cmd_fresh;
        n_rsp.estop_active       = n_estop;
        n_rsp.can_move           = (n_mode == blfs_pkg::MODE_READY) && !n_estop &&
                                   nxt_fb_fresh && nxt_cmd_fresh;
        n_rsp.reset_accepted     = accepted;
        n_rsp.timeout_transition = timed_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= blfs_pkg::MODE_DISC;
            r_fault    <= blfs_pkg::FLT_NONE;
            r_link     <= 1'b0;
            r_fb_seen  <= 1'b0;
            r_cmd_seen <= 1'b0;
            r_estop    <= 1'b0;
            r_fb_age   <= '0;
            r_cmd_age  <= '0;
        end else if (fire) begin
            r_mode     <= n_mode;
            r_fault    <= n_fault;
            r_link     <= n_link;
            r_fb_seen  <= n_fb_seen;
            r_cmd_seen <= n_cmd_seen;
            r_estop    <= n_estop;
            r_fb_age   <= n_fb_age;
            r_cmd_age  <= n_cmd_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    // the fault code is held exactly while the mode is latched
    a_fault_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == blfs_pkg::MODE_FAULT) == (r_fault != blfs_pkg::FLT_NONE))
        else $error("fault code and latched mode disagree");

    a_can_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_rsp.can_move) |->
        (r_rsp.mode == blfs_pkg::MODE_READY && !r_rsp.estop_active &&
         r_rsp.feedback_fresh && r_rsp.command_fresh))
        else $error("can_move without its conditions");

    a_reset_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_rsp.reset_accepted) |->
        (r_rsp.fault == blfs_pkg::FLT_NONE && r_rsp.mode == blfs_pkg::MODE_READY))
        else $error("accepted reset left a fault");

    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && timed_out) |=> (r_fault == blfs_pkg::FLT_TIMEOUT))
        else $error("timeout transition did not latch timeout");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_free) |=> r_in_vld)
        else $error("stalled request dropped");

endmodule

// ===== test/base_link_fault_supervisor_test.sv =====
// Self-checking testbench for the base link fault supervisor: directed and random events.
module base_link_fault_supervisor_test;

    timeunit 1ns;
    timeprecision 1ps;

    // narrow ages so that saturation is reached in a few hundred ticks
    localparam int unsigned AGE_W       = 8;
    localparam logic [AGE_W-1:0] AGE_SAT = {AGE_W{1'b1}};
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE_CYC  = 4;
    localparam int unsigned MAX_REPORTS = 10;

    // command codes past the last defined one, and register slots past the list
    localparam logic [blfs_pkg::CMD_W-1:0]     CMD_SPARE_LO = 4'd13;
    localparam logic [blfs_pkg::CMD_W-1:0]     CMD_SPARE_HI = 4'd15;
    localparam logic [blfs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [blfs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic i_clk;
    logic i_rst_n;

    blfs_req_if req_ch ();
    blfs_rsp_if rsp_ch ();
    blfs_cfg_if cfg_ch ();

    base_link_fault_supervisor #(.AGE_WIDTH(AGE_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // supervisor shadow state
    blfs_pkg::t_mode            sv_mode;
    blfs_pkg::t_fault           sv_fault;
    logic                       sv_link;
    logic                       sv_fb_seen;
    logic [AGE_W-1:0]           sv_fb_age;
    logic                       sv_cmd_seen;
    logic [AGE_W-1:0]           sv_cmd_age;
    logic                       sv_estop;
    logic [blfs_pkg::TMO_W-1:0] sv_cmd_tmo;
    logic [blfs_pkg::TMO_W-1:0] sv_fb_tmo;

    blfs_pkg::t_rsp snapshot_q[$];
    int unsigned    mismatches;
    int unsigned    idle_cycles;
    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic fb_is_fresh();
        return sv_link && sv_fb_seen && (sv_fb_age <= sv_fb_tmo);
    endfunction

    function automatic logic cmd_is_fresh();
        return sv_cmd_seen && (sv_cmd_age <= sv_cmd_tmo);
    endfunction

    function automatic void clear_records();
        sv_fb_seen  = 1'b0;
        sv_cmd_seen = 1'b0;
        sv_fb_age   = '0;
        sv_cmd_age  = '0;
    endfunction

    // first fault wins
    function automatic void latch_fault(blfs_pkg::t_fault code);
        if (sv_mode != blfs_pkg::MODE_FAULT) sv_fault = code;
        sv_mode = blfs_pkg::MODE_FAULT;
    endfunction

    function automatic void drop_link(logic [blfs_pkg::REASON_W-1:0] rsn);
        sv_link = 1'b0;
        clear_records();
        if (rsn != blfs_pkg::FLT_NONE)
            latch_fault(rsn > blfs_pkg::FLT_TIMEOUT ? blfs_pkg::FLT_SERIAL
                                                    : blfs_pkg::t_fault'(rsn));
        else if (sv_mode != blfs_pkg::MODE_FAULT)
            sv_mode = blfs_pkg::MODE_DISC;
    endfunction

    function automatic blfs_pkg::t_rsp predict_snapshot(blfs_pkg::t_req r);
        blfs_pkg::t_rsp s;
        logic took_reset;
        logic timed_out;
        took_reset = 1'b0;
        timed_out  = 1'b0;
        case (r.cmd)
            blfs_pkg::CMD_TICK: begin
                if (sv_fb_age != AGE_SAT) sv_fb_age = sv_fb_age + 1'b1;
                if (sv_cmd_age != AGE_SAT) sv_cmd_age = sv_cmd_age + 1'b1;
            end
            blfs_pkg::CMD_LINK_UP: begin
                sv_link = 1'b1;
                clear_records();
                if (sv_mode != blfs_pkg::MODE_FAULT) sv_mode = blfs_pkg::MODE_WAIT;
            end
            blfs_pkg::CMD_LINK_DOWN: drop_link(r.down_reason);
            blfs_pkg::CMD_FEEDBACK: begin
                sv_fb_seen = 1'b1;
                sv_fb_age  = '0;
                if (sv_link && sv_mode != blfs_pkg::MODE_FAULT) sv_mode = blfs_pkg::MODE_READY;
            end
            blfs_pkg::CMD_VALID_CMD: begin
                sv_cmd_seen = 1'b1;
                sv_cmd_age  = '0;
            end
            blfs_pkg::CMD_INVALIDATE: begin
                sv_cmd_seen = 1'b0;
                sv_cmd_age  = '0;
            end
            blfs_pkg::CMD_INVALID:  latch_fault(blfs_pkg::FLT_INVALID);
            blfs_pkg::CMD_IO_FAIL:  drop_link(blfs_pkg::FLT_SERIAL);
            blfs_pkg::CMD_CFG_FAIL: latch_fault(blfs_pkg::FLT_MCU);
            blfs_pkg::CMD_ESTOP: begin
                sv_estop = r.estop_level;
                if (r.estop_level) latch_fault(blfs_pkg::FLT_ESTOP);
            end
            blfs_pkg::CMD_EVALUATE: begin
                if (sv_mode != blfs_pkg::MODE_FAULT) begin
                    if (!sv_link) sv_mode = blfs_pkg::MODE_DISC;
                    else if (!sv_fb_seen) sv_mode = blfs_pkg::MODE_WAIT;
                    else if (!fb_is_fresh()) begin
                        latch_fault(blfs_pkg::FLT_TIMEOUT);
                        timed_out = 1'b1;
                    end else sv_mode = blfs_pkg::MODE_READY;
                end
            end
            blfs_pkg::CMD_RESET: begin
                if (sv_link && !sv_estop && fb_is_fresh()) begin
                    sv_fault    = blfs_pkg::FLT_NONE;
                    sv_mode     = blfs_pkg::MODE_READY;
                    sv_cmd_seen = 1'b0;
                    sv_cmd_age  = '0;
                    took_reset  = 1'b1;
                end
            end
            default: ;
        endcase
        s.mode               = sv_mode;
        s.fault              = sv_fault;
        s.link_is_open       = sv_link;
        s.feedback_fresh     = fb_is_fresh();
        s.command_fresh      = cmd_is_fresh();
        s.estop_active       = sv_estop;
        s.can_move           = (sv_mode == blfs_pkg::MODE_READY) && !sv_estop &&
                               fb_is_fresh() && cmd_is_fresh();
        s.reset_accepted     = took_reset;
        s.timeout_transition = timed_out;
        return s;
    endfunction

    task automatic compare_field(string name, logic [2:0] want, logic [2:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t mismatch %s: expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    task automatic check_snapshot(blfs_pkg::t_rsp got);
        blfs_pkg::t_rsp want;
        if (snapshot_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t unexpected result %h", $realtime, got);
        end else begin
            want = snapshot_q.pop_front();
            compare_field("mode", 3'(want.mode), 3'(got.mode));
            compare_field("fault", want.fault, got.fault);
            compare_field("link_is_open", 3'(want.link_is_open), 3'(got.link_is_open));
            compare_field("feedback_fresh", 3'(want.feedback_fresh),
                          3'(got.feedback_fresh));
            compare_field("command_fresh", 3'(want.command_fresh), 3'(got.command_fresh));
            compare_field("estop_active", 3'(want.estop_active), 3'(got.estop_active));
            compare_field("can_move", 3'(want.can_move), 3'(got.can_move));
            compare_field("reset_accepted", 3'(want.reset_accepted),
                          3'(got.reset_accepted));
            compare_field("timeout_transition", 3'(want.timeout_transition),
                          3'(got.timeout_transition));
        end
    endtask

    // sample every handshake at the rising edge; check before predicting
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) check_snapshot(rsp_ch.data);
            if (req_ch.valid && req_ch.ready) snapshot_q.push_back(predict_snapshot(req_ch.data));
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.data.idx == blfs_pkg::REG_CMD_TMO) sv_cmd_tmo = cfg_ch.data.data;
                else if (cfg_ch.data.idx == blfs_pkg::REG_FB_TMO) sv_fb_tmo = cfg_ch.data.data;
            end
            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_event(logic [blfs_pkg::CMD_W-1:0] c,
                              logic [blfs_pkg::REASON_W-1:0] rsn, logic lvl);
        blfs_pkg::t_req r;
        r.cmd         = c;
        r.down_reason = rsn;
        r.estop_level = lvl;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // drop valid, wait for every snapshot, then let the pipeline empty
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (snapshot_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [blfs_pkg::CFG_IDX_W-1:0] idx,
                             logic [blfs_pkg::TMO_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.data.idx  <= idx;
        cfg_ch.data.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_pressure(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_event_walk();
        set_pressure(0, 0);
        send_event(blfs_pkg::CMD_QUERY, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_EVALUATE, 3'd7, 1'b1);
        send_event(blfs_pkg::CMD_LINK_UP, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_EVALUATE, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_RESET, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_FEEDBACK, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_VALID_CMD, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_INVALIDATE, 3'd7, 1'b1);
        send_event(blfs_pkg::CMD_VALID_CMD, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_TICK, blfs_pkg::FLT_NONE, 1'b0);
        send_event(CMD_SPARE_LO, 3'd7, 1'b1);
        send_event(CMD_SPARE_HI, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_INVALID, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_CFG_FAIL, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_RESET, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_ESTOP, blfs_pkg::FLT_NONE, 1'b1);
        send_event(blfs_pkg::CMD_RESET, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_ESTOP, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_RESET, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_IO_FAIL, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_LINK_UP, blfs_pkg::FLT_NONE, 1'b0);
        // reason past the fault list maps to serial io; the earlier io fault stays latched
        send_event(blfs_pkg::CMD_LINK_DOWN, 3'd7, 1'b0);
        send_event(blfs_pkg::CMD_LINK_UP, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_LINK_DOWN, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_LINK_DOWN, blfs_pkg::FLT_TIMEOUT, 1'b0);
        drain();
    endtask

    task automatic test_feedback_timeout();
        set_pressure(0, 0);
        write_reg(blfs_pkg::REG_CMD_TMO, '0);
        write_reg(blfs_pkg::REG_FB_TMO, '0);
        // writes past the register list change nothing
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0001);
        send_event(blfs_pkg::CMD_ESTOP, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_LINK_UP, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_FEEDBACK, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_RESET, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_VALID_CMD, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_TICK, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_EVALUATE, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_RESET, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_FEEDBACK, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_LINK_DOWN, 3'd6, 1'b0);
        send_event(blfs_pkg::CMD_LINK_UP, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_FEEDBACK, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_RESET, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_QUERY, blfs_pkg::FLT_NONE, 1'b0);
        drain();
    endtask

    // hold both records long enough for the ages to pin at their ceiling
    task automatic test_age_saturation();
        set_pressure(0, 0);
        write_reg(blfs_pkg::REG_CMD_TMO, 16'hFFFF);
        write_reg(blfs_pkg::REG_FB_TMO, 16'hFFFF);
        send_event(blfs_pkg::CMD_LINK_UP, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_FEEDBACK, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_VALID_CMD, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_EVALUATE, blfs_pkg::FLT_NONE, 1'b0);
        repeat (int'(AGE_SAT) + 3) send_event(blfs_pkg::CMD_TICK, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_QUERY, blfs_pkg::FLT_NONE, 1'b0);
        send_event(blfs_pkg::CMD_EVALUATE, blfs_pkg::FLT_NONE, 1'b0);
        drain();
    endtask

    task automatic send_random_event();
        int unsigned pick;
        logic [blfs_pkg::CMD_W-1:0]    c;
        logic [blfs_pkg::REASON_W-1:0] rsn;
        logic                          lvl;
        pick = $urandom_range(99);
        rsn  = 3'($urandom_range(7));
        lvl  = 1'($urandom_range(1));
        if (pick < 28) c = blfs_pkg::CMD_TICK;
        else if (pick < 40) c = blfs_pkg::CMD_FEEDBACK;
        else if (pick < 50) c = blfs_pkg::CMD_VALID_CMD;
        else if (pick < 60) c = blfs_pkg::CMD_EVALUATE;
        else if (pick < 66) c = blfs_pkg::CMD_RESET;
        else if (pick < 71) c = blfs_pkg::CMD_LINK_UP;
        else if (pick < 75) begin
            c = blfs_pkg::CMD_LINK_DOWN;
            if ($urandom_range(1)) rsn = blfs_pkg::FLT_NONE;
        end else if (pick < 78) c = blfs_pkg::CMD_QUERY;
        else if (pick < 83) begin
            c   = blfs_pkg::CMD_ESTOP;
            lvl = ($urandom_range(99) < 40);
        end else if (pick < 86) c = blfs_pkg::CMD_INVALIDATE;
        else if (pick < 88) c = blfs_pkg::CMD_INVALID;
        else if (pick < 90) c = blfs_pkg::CMD_IO_FAIL;
        else if (pick < 92) c = blfs_pkg::CMD_CFG_FAIL;
        else c = blfs_pkg::CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        send_event(c, rsn, lvl);
    endtask

    task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                       logic [blfs_pkg::TMO_W-1:0] cmd_tmo,
                                       logic [blfs_pkg::TMO_W-1:0] fb_tmo,
                                       int unsigned count);
        int unsigned sent;
        int unsigned pick;
        int unsigned burst;
        write_reg(blfs_pkg::REG_CMD_TMO, cmd_tmo);
        write_reg(blfs_pkg::REG_FB_TMO, fb_tmo);
        set_pressure(send_pct, recv_pct);
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                // recovery: release e-stop, open, feed back, clear, command, evaluate
                send_event(blfs_pkg::CMD_ESTOP, 3'($urandom_range(7)), 1'b0);
                send_event(blfs_pkg::CMD_LINK_UP, 3'($urandom_range(7)),
                           1'($urandom_range(1)));
                send_event(blfs_pkg::CMD_FEEDBACK, 3'($urandom_range(7)),
                           1'($urandom_range(1)));
                send_event(blfs_pkg::CMD_RESET, 3'($urandom_range(7)),
                           1'($urandom_range(1)));
                send_event(blfs_pkg::CMD_VALID_CMD, 3'($urandom_range(7)),
                           1'($urandom_range(1)));
                send_event(blfs_pkg::CMD_EVALUATE, 3'($urandom_range(7)),
                           1'($urandom_range(1)));
                sent += 6;
            end else if (pick < 20) begin
                // run the ages across the smaller timeout
                burst = $urandom_range(60, 1);
                repeat (burst) send_event(blfs_pkg::CMD_TICK, 3'($urandom_range(7)),
                                          1'($urandom_range(1)));
                send_event(blfs_pkg::CMD_EVALUATE, blfs_pkg::FLT_NONE, 1'b0);
                sent += burst + 1;
            end else begin
                send_random_event();
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.data      = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        mismatches       = 0;
        idle_cycles      = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        sv_mode          = blfs_pkg::MODE_DISC;
        sv_fault         = blfs_pkg::FLT_NONE;
        sv_link          = 1'b0;
        sv_estop         = 1'b0;
        sv_cmd_tmo       = blfs_pkg::TMO_RESET;
        sv_fb_tmo        = blfs_pkg::TMO_RESET;
        clear_records();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_event_walk();
        test_feedback_timeout();
        test_age_saturation();
        test_random_traffic(0, 0, 16'd0, 16'hFFFF, 100);
        test_random_traffic(86, 0, 16'hFFFF, 16'd0, 100);
        test_random_traffic(0, 86, 16'($urandom_range(25, 1)), 16'($urandom_range(25, 1)), 100);
        test_random_traffic(13, 13, 16'($urandom_range(40, 5)), blfs_pkg::TMO_RESET, 100);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
